FILE: rtl/gdkt_pkg.sv
// ----------------------------------------------------------------------------
// gdkt_pkg: shared types and helpers for the gated depth Kalman tracker
// Fixed-point types, lane command and result records, register indexes and
// the saturation helper used by the lanes and the top level.
// ----------------------------------------------------------------------------
package gdkt_pkg;

  // Signed Q16.16 value and unsigned 31-bit Q15.16 variance.
  typedef logic signed [31:0] q_t;
  typedef logic [30:0]        var_t;

  // Number of lanes: horizontal, vertical and depth.
  localparam int NUM_LANES = 3;
  localparam int LANE_Z    = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_VAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_VAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DV  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 2'd3;

  // Reset values of the configuration registers.
  localparam var_t POS_VAR_RST  = 31'd655360;
  localparam var_t VEL_VAR_RST  = 31'd327680;
  localparam var_t INIT_DV_RST  = 31'd65536;
  localparam var_t GATE_RST     = 31'd65536;

  // One tenth in Q15.16.
  localparam var_t Q_TENTH = 31'd6554;

  // Divider geometry: numerator, denominator, clamped quotient and counter widths.
  localparam int NUM_W = 96;
  localparam int DEN_W = 62;
  localparam int QUO_W = 34;
  localparam int CNT_W = 6;

  // Work handed to one lane.
  typedef struct packed {
    q_t          pos;
    q_t          vel;
    q_t          meas;
    var_t        pv;
    var_t        vv;
    var_t        gate;
    logic        gate_en;
    logic [31:0] adt;
    logic        dneg;
  } lane_cmd_t;

  // What one lane returns.
  typedef struct packed {
    q_t   pos;
    q_t   vel;
    logic accepted;
  } lane_res_t;

  // Saturate a signed value to the signed 32-bit range.
  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/gdkt_in_if.sv
// ----------------------------------------------------------------------------
// gdkt_in_if: measurement request channel
// Carries one measured position, depth and time stamp per request.
// ----------------------------------------------------------------------------
interface gdkt_in_if;
  import gdkt_pkg::*;

  logic        valid;
  logic        ready;
  q_t          meas_x;
  q_t          meas_y;
  q_t          meas_depth;
  logic [47:0] time_stamp;

  modport source (output valid, meas_x, meas_y, meas_depth, time_stamp, input ready);
  modport sink   (input valid, meas_x, meas_y, meas_depth, time_stamp, output ready);
endinterface

FILE: rtl/gdkt_out_if.sv
// ----------------------------------------------------------------------------
// gdkt_out_if: estimate result channel
// Carries the filtered state, depth variance and flags produced for each measurement.
// ----------------------------------------------------------------------------
interface gdkt_out_if;
  import gdkt_pkg::*;

  logic valid;
  logic ready;
  q_t   est_x;
  q_t   est_y;
  q_t   est_depth;
  q_t   est_vx;
  q_t   est_vy;
  q_t   est_vz;
  var_t cur_depth_variance;
  logic depth_accepted;
  logic first_item;

  modport source (output valid, est_x, est_y, est_depth, est_vx, est_vy, est_vz,
                  cur_depth_variance, depth_accepted, first_item, input ready);
  modport sink   (input valid, est_x, est_y, est_depth, est_vx, est_vy, est_vz,
                  cur_depth_variance, depth_accepted, first_item, output ready);
endinterface

FILE: rtl/gdkt_div.sv
// ----------------------------------------------------------------------------
// gdkt_div: restoring divider with clamped quotient
// Divides a 96-bit numerator by a 62-bit denominator one quotient bit per
// cycle and always runs the full count, so every divide takes the same time.
// A quotient that does not fit is clamped to all ones.
// ----------------------------------------------------------------------------
module gdkt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gdkt_pkg::NUM_W-1:0] num,
  input  logic [gdkt_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [gdkt_pkg::QUO_W-1:0] quo
);
  import gdkt_pkg::*;

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             ovf_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Trial subtraction of the next partial remainder.
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, den};

  // Control: iteration count and run flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(QUO_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Datapath: remainder, numerator bits still to come, quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      low_r <= num[QUO_W-1:0];
      quo_r <= '0;
      ovf_r <= !(num[NUM_W-1:QUO_W] < den);
    end else if (run_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign busy = run_r;
  assign quo  = ovf_r ? '1 : quo_r;

endmodule

FILE: rtl/gdkt_lane.sv
// ----------------------------------------------------------------------------
// gdkt_lane: one constant-velocity Kalman axis
// Predicts the axis, rebuilds its covariance terms, gates (when enabled) and corrects it
// with one shared multiplier over several steps and two dividers.
// ----------------------------------------------------------------------------
module gdkt_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gdkt_pkg::lane_cmd_t  cmd,
  output logic                 done,
  output gdkt_pkg::lane_res_t  res
);
  import gdkt_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRED = 4'd1;
  localparam logic [3:0] ST_XP   = 4'd2;
  localparam logic [3:0] ST_A    = 4'd3;
  localparam logic [3:0] ST_AV0  = 4'd4;
  localparam logic [3:0] ST_AV1  = 4'd5;
  localparam logic [3:0] ST_P00  = 4'd6;
  localparam logic [3:0] ST_P01  = 4'd7;
  localparam logic [3:0] ST_N0   = 4'd8;
  localparam logic [3:0] ST_N1   = 4'd9;
  localparam logic [3:0] ST_N2   = 4'd10;
  localparam logic [3:0] ST_DIV  = 4'd11;
  localparam logic [3:0] ST_WAIT = 4'd12;

  logic [3:0]       state_r;
  lane_cmd_t        cmd_r;
  logic [NUM_W-1:0] acc_r;
  q_t               xp_r;
  logic [46:0]      a_r;
  logic [61:0]      p00_r;
  logic [47:0]      p01_r;
  logic [61:0]      s_r;
  logic             r_neg_r;
  logic [32:0]      r_mag_r;
  logic             accept_r;
  logic [NUM_W-1:0] numa_r;
  lane_res_t        res_r;
  logic             done_r;

  logic [32:0]       ma;
  logic [31:0]       mb;
  logic [64:0]       prod;
  logic [31:0]       vel_mag;
  logic [NUM_W-1:0]  acc_rnd;
  logic signed [49:0] scl_s;
  logic signed [49:0] xsum;
  logic signed [32:0] r_full;
  logic [NUM_W-1:0]  numb;
  logic              busy_a, busy_b;
  logic [QUO_W-1:0]  quo_a, quo_b;
  logic              div_start;
  logic signed [35:0] qa_s, qb_s, psum, vsum;
  logic              skip;

  assign vel_mag = cmd_r.vel[31] ? 32'(-cmd_r.vel) : 32'(cmd_r.vel);
  assign acc_rnd = acc_r + NUM_W'(32768);
  assign scl_s   = $signed({3'b000, acc_rnd[62:16]});
  assign xsum    = 50'(cmd_r.pos) + ((cmd_r.vel[31] ^ cmd_r.dneg) ? -scl_s : scl_s);
  assign r_full  = 33'(cmd_r.meas) - 33'(xp_r);
  assign numb    = acc_r + NUM_W'(s_r[61:1]);
  assign div_start = (state_r == ST_DIV);

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_PRED: begin ma = {1'b0, vel_mag};         mb = cmd_r.adt; end
      ST_XP:   begin ma = {1'b0, cmd_r.adt};       mb = cmd_r.adt; end
      ST_AV0:  begin ma = {1'b0, a_r[31:0]};       mb = {1'b0, cmd_r.vv}; end
      ST_AV1:  begin ma = {18'b0, a_r[46:32]};     mb = {1'b0, cmd_r.vv}; end
      ST_P00:  begin ma = {1'b0, cmd_r.adt};       mb = {1'b0, cmd_r.vv}; end
      ST_P01:  begin ma = r_mag_r;                 mb = p00_r[31:0]; end
      ST_N0:   begin ma = r_mag_r;                 mb = {2'b0, p00_r[61:32]}; end
      ST_N1:   begin ma = r_mag_r;                 mb = p01_r[31:0]; end
      ST_N2:   begin ma = r_mag_r;                 mb = {16'b0, p01_r[47:32]}; end
      default: begin ma = '0;                      mb = '0; end
    endcase
  end

  assign prod = 65'(ma) * 65'(mb);

  // Final correction of position and velocity from the two quotients.
  assign qa_s = $signed({2'b00, quo_a});
  assign qb_s = $signed({2'b00, quo_b});
  assign psum = 36'(xp_r) + (r_neg_r ? -qa_s : qa_s);
  assign vsum = 36'(cmd_r.vel) + ((r_neg_r ^ cmd_r.dneg) ? -qb_s : qb_s);
  assign skip = !accept_r || (s_r == '0);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (start) state_r <= ST_PRED;
        ST_PRED: state_r <= ST_XP;
        ST_XP:   state_r <= ST_A;
        ST_A:    state_r <= ST_AV0;
        ST_AV0:  state_r <= ST_AV1;
        ST_AV1:  state_r <= ST_P00;
        ST_P00:  state_r <= ST_P01;
        ST_P01:  state_r <= ST_N0;
        ST_N0:   state_r <= ST_N1;
        ST_N1:   state_r <= ST_N2;
        ST_N2:   state_r <= ST_DIV;
        ST_DIV:  state_r <= ST_WAIT;
        ST_WAIT: begin
          if (!busy_a && !busy_b) begin
            state_r <= ST_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (start) cmd_r <= cmd;
      ST_PRED: acc_r <= NUM_W'(prod);
      ST_XP: begin
        xp_r  <= sat_q(64'(xsum));
        acc_r <= NUM_W'(prod);
      end
      ST_A:   a_r   <= acc_rnd[62:16];
      ST_AV0: acc_r <= NUM_W'(prod);
      ST_AV1: acc_r <= acc_r + NUM_W'({prod, 32'b0});
      ST_P00: begin
        p00_r   <= {30'b0, cmd_r.pv, 1'b0} + acc_rnd[77:16];
        acc_r   <= NUM_W'(prod);
        r_neg_r <= r_full[32];
        r_mag_r <= r_full[32] ? 33'(-r_full) : 33'(r_full);
      end
      ST_P01: begin
        p01_r    <= acc_rnd[63:16];
        s_r      <= p00_r + 62'(cmd_r.pv);
        accept_r <= !cmd_r.gate_en || (r_mag_r < {2'b0, cmd_r.gate});
        acc_r    <= NUM_W'(prod);
      end
      ST_N0: acc_r <= acc_r + NUM_W'({prod, 32'b0});
      ST_N1: begin
        numa_r <= acc_r + NUM_W'(s_r[61:1]);
        acc_r  <= NUM_W'(prod);
      end
      ST_N2: acc_r <= acc_r + NUM_W'({prod, 32'b0});
      ST_WAIT: begin
        if (!busy_a && !busy_b) begin
          res_r.accepted <= accept_r;
          res_r.pos      <= skip ? xp_r : sat_q(64'(psum));
          res_r.vel      <= skip ? cmd_r.vel : sat_q(64'(vsum));
        end
      end
      default: ;
    endcase
  end

  // Position gain and velocity gain quotients.
  gdkt_div u_div_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numa_r),
    .den   (s_r),
    .busy  (busy_a),
    .quo   (quo_a)
  );

  gdkt_div u_div_vel (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numb),
    .den   (s_r),
    .busy  (busy_b),
    .quo   (quo_b)
  );

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/gated_depth_kalman_tracker.sv
// ----------------------------------------------------------------------------
// gated_depth_kalman_tracker: three-axis constant-velocity tracker
// The first item of a track goes from the preparation step straight to the
// output register; later items pass one preparation step, 11 lane steps, the
// divide with its finishing step, and two steps to collect and register.
// One request is worked on at a time; the next one can be taken the cycle
// after the previous estimate is written into the output register.
// Reset (synchronous, active low) restores the register defaults and empties
// the track, so the next request starts a new one.
// ----------------------------------------------------------------------------
module gated_depth_kalman_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  gdkt_in_if.sink                          in_req,
  gdkt_out_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [gdkt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  gdkt_pkg::var_t                   cfg_data
);
  import gdkt_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_PREP = 2'd1;
  localparam logic [1:0] T_RUN  = 2'd2;
  localparam logic [1:0] T_EMIT = 2'd3;

  logic [1:0]  state_r;
  var_t        pos_var_r, vel_var_r, gate_r, dv_r;
  q_t          pos_r [NUM_LANES];
  q_t          vel_r [NUM_LANES];
  q_t          meas_r [NUM_LANES];
  logic [47:0] t_r, prev_t_r;
  logic        started_r, first_r, accepted_r;
  logic        out_valid_r;
  q_t          est_pos_r [NUM_LANES];
  q_t          est_vel_r [NUM_LANES];
  var_t        est_dv_r;
  logic        est_acc_r, est_first_r;

  logic [47:0]        diff;
  q_t                 dts;
  logic [31:0]        adt;
  logic signed [32:0] dz;
  logic [32:0]        err;
  var_t               dv_nxt;
  lane_cmd_t          lane_cmd [NUM_LANES];
  lane_res_t          lane_res [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  logic               lane_start;
  logic               out_free;

  // Time step and depth variance adaptation.
  assign diff   = t_r - prev_t_r;
  assign dts    = sat_q(64'($signed(diff)));
  assign adt    = dts[31] ? 32'(-dts) : 32'(dts);
  assign dz     = 33'(meas_r[LANE_Z]) - 33'(pos_r[LANE_Z]);
  assign err    = dz[32] ? 33'(-dz) : 33'(dz);
  assign dv_nxt = (err < {2'b0, gate_r}) ? var_t'(Q_TENTH + 31'(33'(err + 33'd1) >> 1)) : dv_r;

  assign lane_start = (state_r == T_PREP) && started_r;
  assign out_free   = !out_valid_r || out_res.ready;

  // Lane commands and lanes.
  genvar g;
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      always_comb begin
        lane_cmd[g].pos     = pos_r[g];
        lane_cmd[g].vel     = vel_r[g];
        lane_cmd[g].meas    = meas_r[g];
        lane_cmd[g].pv      = (g == LANE_Z) ? dv_nxt : pos_var_r;
        lane_cmd[g].vv      = vel_var_r;
        lane_cmd[g].gate    = gate_r;
        lane_cmd[g].gate_en = (g == LANE_Z);
        lane_cmd[g].adt     = adt;
        lane_cmd[g].dneg    = dts[31];
      end

      gdkt_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .cmd   (lane_cmd[g]),
        .done  (lane_done[g]),
        .res   (lane_res[g])
      );
    end
  endgenerate

  // Control, track state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      pos_var_r   <= POS_VAR_RST;
      vel_var_r   <= VEL_VAR_RST;
      gate_r      <= GATE_RST;
      dv_r        <= INIT_DV_RST;
      started_r   <= 1'b0;
      prev_t_r    <= '0;
      first_r     <= 1'b0;
      accepted_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (out_res.ready && (state_r != T_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POS_VAR: pos_var_r <= cfg_data;
          CFG_VEL_VAR: vel_var_r <= cfg_data;
          CFG_INIT_DV: dv_r      <= cfg_data;
          CFG_GATE:    gate_r    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        T_IDLE: if (in_req.valid) state_r <= T_PREP;
        T_PREP: begin
          prev_t_r <= t_r;
          if (!started_r) begin
            started_r  <= 1'b1;
            first_r    <= 1'b1;
            accepted_r <= 1'b0;
            for (int i = 0; i < NUM_LANES; i++) begin
              pos_r[i] <= meas_r[i];
              vel_r[i] <= '0;
            end
            state_r <= T_EMIT;
          end else begin
            dv_r    <= dv_nxt;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (lane_done[0]) begin
            first_r    <= 1'b0;
            accepted_r <= lane_res[LANE_Z].accepted;
            for (int i = 0; i < NUM_LANES; i++) begin
              pos_r[i] <= lane_res[i].pos;
              vel_r[i] <= lane_res[i].vel;
            end
            state_r <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // Request capture and output register.
  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && in_req.valid) begin
      meas_r[0] <= in_req.meas_x;
      meas_r[1] <= in_req.meas_y;
      meas_r[2] <= in_req.meas_depth;
      t_r       <= in_req.time_stamp;
    end
    if (state_r == T_EMIT && out_free) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        est_pos_r[i] <= pos_r[i];
        est_vel_r[i] <= vel_r[i];
      end
      est_dv_r    <= dv_r;
      est_acc_r   <= accepted_r;
      est_first_r <= first_r;
    end
  end

  assign in_req.ready               = (state_r == T_IDLE);
  assign out_res.valid              = out_valid_r;
  assign out_res.est_x              = est_pos_r[0];
  assign out_res.est_y              = est_pos_r[1];
  assign out_res.est_depth          = est_pos_r[2];
  assign out_res.est_vx             = est_vel_r[0];
  assign out_res.est_vy             = est_vel_r[1];
  assign out_res.est_vz             = est_vel_r[2];
  assign out_res.cur_depth_variance = est_dv_r;
  assign out_res.depth_accepted     = est_acc_r;
  assign out_res.first_item         = est_first_r;

  // The lanes run in lock step and finish together.
  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (lane_done[1] && lane_done[2]))
    else $error("lanes finished out of step");

  // Lanes only finish while the controller waits for them.
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (state_r == T_RUN))
    else $error("lane result outside run state");

  // A track-starting estimate is only shown once the track has started.
  a_first_started: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && est_first_r) |-> started_r)
    else $error("first estimate without a started track");

endmodule
